>>> hw/rtl/button_scan_debounce_combo_unit_defines.svh
// ----------------------------------------------------------------------------
// Button scan debounce: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_SCAN_DEBOUNCE_COMBO_UNIT_DEFINES_SVH
`define BUTTON_SCAN_DEBOUNCE_COMBO_UNIT_DEFINES_SVH

// same-cycle implication
`define BSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// Types and constants shared by the button scan debounce controller,
// datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

  // sizes
  localparam int BUTTONS    = 24;               // buttons that may publish
  localparam int COMBOS     = 4;                // combination entries scanned
  localparam int COMBO_REGS = 4;                // combination registers
  localparam int RAW_W      = 32;
  localparam int BTN_W      = 24;               // button word width
  localparam int CODE_W     = 8;
  localparam int CFG_W      = 32;
  localparam int CFG_IW     = 3;
  localparam int TICK_W     = 4;
  localparam int NEVT       = COMBOS + BUTTONS; // event slots per sample
  localparam int EVT_W      = $clog2(NEVT);
  localparam int COMBO_IW   = $clog2(COMBO_REGS);
  localparam int BTN_IW     = $clog2(BTN_W);

  // reset values
  localparam logic [TICK_W-1:0] TICKS_RST  = 4'd4;
  localparam logic [BTN_W-1:0]  ENABLE_RST = {BTN_W{1'b1}};

  // register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_DEBOUNCE_OFF  = 3'd0,
    CFG_SETTLE_TICKS  = 3'd1,
    CFG_BUTTON_ENABLE = 3'd2,
    CFG_COMBO_0       = 3'd3,
    CFG_COMBO_1       = 3'd4,
    CFG_COMBO_2       = 3'd5,
    CFG_COMBO_3       = 3'd6
  } cfg_reg_t;

  // event kinds
  localparam logic KIND_COMBO  = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the sample, update state, build event vector
    logic step;   // move to the next event slot
    logic emit;   // place the current slot in the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;       // current slot has an event
    logic last;      // no event remains after the current slot
    logic none;      // no event remains at all
    logic out_busy;  // output register holds an untaken event
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/button_scan_debounce_combo_unit.sv
// ----------------------------------------------------------------------------
// button_scan_debounce_combo_unit
// Debounces a polled active-low button word and emits combination key and
// single button events, one event per transaction on the output channel.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    raw_word
//  out      source     out_valid / out_ready  event_kind event_code
//                                             is_pressed last_event
//  cfg      sink       cfg_we (no wait)       cfg_index cfg_data
//
//  A sample is taken, then the sequencer walks the 28 event slots
//  (4 combinations, 24 buttons) one per cycle while the output is not
//  stalled, ending early once no event remains. Each event waits in a one
//  deep output register; a stalled output holds the walk at that slot.
//  Reset (rst, synchronous) restores register defaults and clears state.
// ----------------------------------------------------------------------------
`default_nettype none

module button_scan_debounce_combo_unit
  import bsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [RAW_W-1:0]  raw_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   event_kind,
  output logic [CODE_W-1:0]      event_code,
  output logic                   is_pressed,
  output logic                   last_event
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  bsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  bsd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .raw_word   (raw_word),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .event_kind (event_kind),
    .event_code (event_code),
    .is_pressed (is_pressed),
    .last_event (last_event)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bsd_ctrl.sv
// ----------------------------------------------------------------------------
// bsd_ctrl
// Sequencer: accepts one sample, then walks the event slots and issues
// emit commands while the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_ctrl
  import bsd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.none) begin
          state_next = ST_IDLE;
        end else if (status.hit) begin
          // wait for the output register before emitting
          if (!status.out_busy) begin
            cmd.emit = 1'b1;
            cmd.step = 1'b1;
            if (status.last) begin
              state_next = ST_IDLE;
            end
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/bsd_datapath.sv
// ----------------------------------------------------------------------------
// bsd_datapath
// Configuration registers, debounce state, event vector and the output
// register for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_datapath
  import bsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic [RAW_W-1:0]  raw_word,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   event_kind,
  output logic [CODE_W-1:0]      event_code,
  output logic                   is_pressed,
  output logic                   last_event
);

  // configuration
  logic              debounce_off;
  logic [TICK_W-1:0] settle_ticks;
  logic [BTN_W-1:0]  button_enable;
  logic [CFG_W-1:0]  combo_entry [COMBO_REGS];

  // debounce state
  logic [BTN_W-1:0]  prev_buttons;
  logic [BTN_W-1:0]  pending;
  logic [TICK_W-1:0] settle_count;
  logic [COMBOS-1:0] combo_held;

  // event walk
  logic [NEVT-1:0]   rem;
  logic [COMBOS-1:0] combo_press;
  logic [EVT_W-1:0]  idx;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_off  <= 1'b0;
      settle_ticks  <= TICKS_RST;
      button_enable <= ENABLE_RST;
      for (int k = 0; k < COMBO_REGS; k++) begin
        combo_entry[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_OFF:  debounce_off  <= cfg_data[0];
        CFG_SETTLE_TICKS:  settle_ticks  <= cfg_data[TICK_W-1:0];
        CFG_BUTTON_ENABLE: button_enable <= cfg_data[BTN_W-1:0];
        CFG_COMBO_0:       combo_entry[0] <= cfg_data;
        CFG_COMBO_1:       combo_entry[1] <= cfg_data;
        CFG_COMBO_2:       combo_entry[2] <= cfg_data;
        CFG_COMBO_3:       combo_entry[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample evaluation
  logic [BTN_W-1:0]  buttons;
  logic              changed;
  logic [BTN_W-1:0]  pend_upd;
  logic [TICK_W-1:0] cnt_eff;
  logic              publish;
  logic [COMBOS-1:0] combo_hit;
  logic [COMBOS-1:0] combo_full;
  logic [COMBOS-1:0] held_next;
  logic [BTN_W-1:0]  btn_hits;

  assign buttons  = ~raw_word[RAW_W-1:RAW_W-BTN_W];
  assign changed  = buttons != prev_buttons;
  assign pend_upd = changed ? (pending | (buttons ^ prev_buttons)) : pending;
  assign cnt_eff  = changed ? '0 : settle_count;
  assign publish  = (cnt_eff >= settle_ticks) || debounce_off;
  assign btn_hits = publish ? (pend_upd & button_enable) : '0;

  // combination scan, stops at the first empty entry
  always_comb begin
    logic             alive;
    logic [BTN_W-1:0] mask;
    logic             relc;
    alive = 1'b1;
    for (int i = 0; i < COMBOS; i++) begin
      mask  = combo_entry[i][BTN_W-1:0];
      alive = alive && (combo_entry[i][CFG_W-1:BTN_W] != '0) && (mask != '0);
      combo_full[i] = (buttons & mask) == mask;
      relc = combo_held[i] && (((buttons & pend_upd) ^ mask) != '0);
      combo_hit[i]  = changed && alive && (combo_full[i] || relc);
      if (changed && alive && combo_full[i]) begin
        held_next[i] = 1'b1;
      end else if (changed && alive && relc) begin
        held_next[i] = 1'b0;
      end else begin
        held_next[i] = combo_held[i];
      end
    end
  end

  // state update on load, event vector walk
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_buttons <= '0;
      pending      <= '0;
      settle_count <= '0;
      combo_held   <= '0;
      rem          <= '0;
      idx          <= '0;
    end else if (cmd.load) begin
      prev_buttons <= buttons;
      pending      <= publish ? '0 : pend_upd;
      settle_count <= (cnt_eff < settle_ticks) ? cnt_eff + 1'b1 : cnt_eff;
      combo_held   <= held_next;
      rem          <= {btn_hits[BUTTONS-1:0], combo_hit};
      idx          <= '0;
    end else if (cmd.step) begin
      rem[idx] <= 1'b0;
      idx      <= idx + 1'b1;
    end
  end

  // press direction of each combination
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      combo_press <= combo_full;
    end
  end

  // current slot decode
  logic                is_combo;
  logic [EVT_W-1:0]    bi;
  logic [COMBO_IW-1:0] cidx;
  logic [BTN_IW-1:0]   bidx;
  logic                cur_last;

  assign is_combo = idx < EVT_W'(COMBOS);
  assign bi       = idx - EVT_W'(COMBOS);
  assign cidx     = COMBO_IW'(idx);
  assign bidx     = BTN_IW'(bi);
  assign cur_last = (rem & ~(NEVT'(1) << idx)) == '0;

  assign status.hit      = rem[idx];
  assign status.last     = cur_last;
  assign status.none     = rem == '0;
  assign status.out_busy = out_valid && !out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_event <= cur_last;
      if (is_combo) begin
        event_kind <= KIND_COMBO;
        event_code <= combo_entry[cidx][CFG_W-1:BTN_W];
        is_pressed <= combo_press[cidx];
      end else begin
        event_kind <= KIND_BUTTON;
        event_code <= CODE_W'(bi);
        is_pressed <= prev_buttons[bidx];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bsd_checker.sv
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level checks of the button scan debounce unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_scan_debounce_combo_unit_defines.svh"

module bsd_checker
  import bsd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              event_kind,
  input wire logic [CODE_W-1:0] event_code,
  input wire logic              is_pressed,
  input wire logic              last_event
);

  // stalled event holds
  `BSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(event_code) && $stable(event_kind) && $stable(is_pressed) && $stable(last_event), "stalled event changed")

  // an accepted sample starts a walk
  `BSD_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready, "ready right after accept")

  // a non-final event means the walk is still running
  `BSD_ASSERT_SAME(a_mid_walk, out_valid && !last_event, !in_ready, "ready before last event")

  // output register empty after reset
  `BSD_ASSERT_SAME(a_rst_empty, $past(rst), !out_valid, "event valid after reset")

endmodule

bind button_scan_debounce_combo_unit bsd_checker u_chk (.*);

`default_nettype wire
